[rtl/tdl_pkg.sv]
// ----------------------------------------------------------------------------
// tdl_pkg - shared definitions for the tick duration splitter
// Data width of the serial divider, reset constants and field codes.
// ----------------------------------------------------------------------------
package tdl_pkg;

  // width of durations, bar lengths and the divider datapath
  localparam int DW = 16;

  // reset value of the bar length and of the whole-note register
  localparam logic [DW-1:0] BAR_RESET = 16'd1920;

  // most pieces per duration
  localparam logic [6:0] PIECE_CAP = 7'd64;

  // request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_NOTE = 1'b1;

  // marks after a piece
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_BAR  = 2'd1;
  localparam logic [1:0] MARK_LINE = 2'd2;

  // split stages of one duration
  typedef enum logic [1:0] {
    ST_BAR  = 2'd0,
    ST_GAP  = 2'd1,
    ST_FILL = 2'd2
  } stage_e;

endpackage

[rtl/tick_duration_to_dotted_lengths.sv]
// ----------------------------------------------------------------------------
// tick_duration_to_dotted_lengths - split note durations into dotted pieces
// Load items fill the signature table; note items yield tied pieces with
// bar and line marks.
// ----------------------------------------------------------------------------
// A note item yields up to 64 pieces, one at a time; no new item is accepted
// until the last piece has been taken. Each piece waits on m_axis_tready, and
// the dot search runs on the single bit-serial divider, which does up to two
// divisions per dot count tried. A zero duration yields no result.
module tick_duration_to_dotted_lengths import tdl_pkg::*; #(
  parameter int SIG_ENTRIES = 16,
  parameter int MAX_DOTS    = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index, entry_start_tick, entry_bar_ticks, duration_ticks, pad
  input  logic [71:0] s_axis_tdata,
  // req_type
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // piece_value, dot_count, tied, mark_after, overlong
  output logic [23:0] m_axis_tdata,
  // tick_form
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int IW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;
  localparam int EW = 48;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PLAN = 6'b000010,
    S_D1   = 6'b000100,
    S_D2   = 6'b001000,
    S_UPD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  // divisor 2^(d+1)-1 of a value with d dots
  function automatic logic [DW-1:0] dot_div(logic [3:0] d);
    logic [DW:0] t;
    t = ({{DW{1'b0}}, 1'b1} << d);
    return DW'((t << 1) - {{DW{1'b0}}, 1'b1});
  endfunction

  // input fields
  logic [3:0]  in_index;
  logic [31:0] in_start;
  logic [15:0] in_bar;
  logic [15:0] in_dur;
  logic        in_fire;
  assign in_index = s_axis_tdata[3:0];
  assign in_start = s_axis_tdata[35:4];
  assign in_bar   = s_axis_tdata[51:36];
  assign in_dur   = s_axis_tdata[67:52];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  state_e        state_q, state_d;
  stage_e        stage_q, stage_d;
  logic [15:0]   whole_q;
  logic [IW-1:0] sig_idx_q, sig_idx_d;
  logic [15:0]   tib_q, tib_d;
  logic [17:0]   til_q, til_d;
  logic [31:0]   tot_q, tot_d;
  logic [15:0]   rem_q, rem_d;
  logic [6:0]    n_q, n_d;
  logic [15:0]   p_q, p_d;
  logic [3:0]    d_q, d_d;
  logic [15:0]   val_q, val_d;
  logic [3:0]    nd_q, nd_d;
  logic          form_q, form_d;
  logic [SIG_ENTRIES-1:0] valid_q;

  logic [15:0]   o_val_q, o_val_d;
  logic [3:0]    o_nd_q, o_nd_d;
  logic          o_form_q, o_form_d;
  logic          o_tied_q, o_tied_d;
  logic [1:0]    o_mark_q, o_mark_d;
  logic          o_over_q, o_over_d;
  logic          o_last_q, o_last_d;

  // whole-note register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q <= BAR_RESET;
    end else if (cfg_we_i) begin
      whole_q <= cfg_data_i;
    end
  end

  // signature table: bar ticks over start tick, valid bits in flops
  logic [IW+3:0] idx_ext;
  logic          load_ok;
  logic [IW:0]   nx;
  logic [EW-1:0] ra_data, rb_data;
  assign idx_ext = {{IW{1'b0}}, in_index};
  assign load_ok = in_fire && (s_axis_tuser[0] == REQ_LOAD)
                   && (idx_ext < (IW+4)'(SIG_ENTRIES));
  assign nx      = {1'b0, sig_idx_q} + (IW+1)'(1);

  tdl_ram #(.WIDTH(EW), .DEPTH(SIG_ENTRIES)) u_sig_ram (
    .clk_i     (clk_i),
    .we_i      (load_ok),
    .waddr_i   (idx_ext[IW-1:0]),
    .wdata_i   ({in_bar, in_start}),
    .ra_addr_i (sig_idx_q),
    .rb_addr_i (nx[IW-1:0]),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_ok) begin
      valid_q[idx_ext[IW-1:0]] <= 1'b1;
    end
  end

  logic [15:0] cur_bar, nbar;
  logic [31:0] nstart;
  logic        nvalid;
  assign cur_bar = valid_q[sig_idx_q] ? ra_data[47:32] : BAR_RESET;
  assign nvalid  = (nx < (IW+1)'(SIG_ENTRIES)) && valid_q[nx[IW-1:0]];
  assign nstart  = rb_data[31:0];
  assign nbar    = rb_data[47:32];

  // shared divider
  logic          div_go, div_done;
  logic [DW-1:0] div_n, div_dv, div_quot, div_rem;

  tdl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_n),
    .divisor_i  (div_dv),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // split planning terms
  logic [15:0] rest, fillp, ly_cur, ly_nxt;
  logic [31:0] gap;
  logic        take_bar, take_gap, last_dot;
  assign rest     = cur_bar - tib_q;
  assign take_bar = (tib_q < cur_bar) && (rest < rem_q);
  assign gap      = nstart - tot_q;
  assign take_gap = nvalid && (nstart > tot_q) && (gap < {16'd0, rem_q});
  assign fillp    = ((cur_bar != 16'd0) && (rem_q >= cur_bar)) ? cur_bar : rem_q;
  assign ly_cur   = dot_div(d_q);
  assign ly_nxt   = dot_div(d_q + 4'd1);
  assign last_dot = (d_q == 4'(MAX_DOTS - 1));

  // counter update terms
  logic [16:0] tib_sum;
  logic [18:0] til_sum;
  logic [15:0] tib1, tib2, bb;
  logic [17:0] til1, til2, bb4;
  logic [31:0] tot1;
  logic        chg;
  logic [15:0] rem_left;
  logic [6:0]  n_next;
  assign tib_sum  = {1'b0, tib_q} + {1'b0, p_q};
  assign tib1     = tib_sum[16] ? 16'hFFFF : tib_sum[15:0];
  assign til_sum  = {1'b0, til_q} + {3'd0, p_q};
  assign til1     = til_sum[18] ? 18'h3FFFF : til_sum[17:0];
  assign tot1     = tot_q + {16'd0, p_q};
  assign chg      = nvalid && (nstart == tot1);
  assign tib2     = chg ? 16'd0 : tib1;
  assign til2     = chg ? 18'd0 : til1;
  assign bb       = chg ? nbar : cur_bar;
  assign bb4      = {bb, 2'b00};
  assign rem_left = rem_q - p_q;
  assign n_next   = n_q + 7'd1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    stage_d   = stage_q;
    sig_idx_d = sig_idx_q;
    tib_d     = tib_q;
    til_d     = til_q;
    tot_d     = tot_q;
    rem_d     = rem_q;
    n_d       = n_q;
    p_d       = p_q;
    d_d       = d_q;
    val_d     = val_q;
    nd_d      = nd_q;
    form_d    = form_q;
    o_val_d   = o_val_q;
    o_nd_d    = o_nd_q;
    o_form_d  = o_form_q;
    o_tied_d  = o_tied_q;
    o_mark_d  = o_mark_q;
    o_over_d  = o_over_q;
    o_last_d  = o_last_q;
    div_go    = 1'b0;
    div_n     = p_q;
    div_dv    = ly_cur;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (s_axis_tuser[0] == REQ_NOTE) && (in_dur != 16'd0)) begin
          rem_d   = in_dur;
          n_d     = 7'd0;
          stage_d = ST_BAR;
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        // pick the next piece length, then start the dot search at zero dots
        case (stage_q)
          ST_BAR: begin
            stage_d = ST_GAP;
            if (take_bar) begin
              p_d     = rest;
              state_d = S_D1;
            end
          end
          ST_GAP: begin
            stage_d = ST_FILL;
            if (take_gap) begin
              p_d     = gap[15:0];
              state_d = S_D1;
            end
          end
          default: begin
            p_d     = fillp;
            state_d = S_D1;
          end
        endcase
        if (state_d == S_D1) begin
          d_d    = 4'd0;
          div_go = 1'b1;
          div_n  = p_d;
          div_dv = dot_div(4'd0);
        end
      end
      S_D1: begin
        // p divisible by 2^(d+1)-1 and the whole note by the base length
        if (div_done) begin
          if ((div_rem == '0) && (div_quot != '0)
              && ((whole_q & (ly_cur >> 1)) == 16'd0)) begin
            div_go  = 1'b1;
            div_n   = whole_q >> d_q;
            div_dv  = div_quot;
            state_d = S_D2;
          end else if (last_dot) begin
            val_d   = p_q;
            nd_d    = 4'd0;
            form_d  = 1'b1;
            state_d = S_UPD;
          end else begin
            d_d    = d_q + 4'd1;
            div_go = 1'b1;
            div_dv = ly_nxt;
          end
        end
      end
      S_D2: begin
        if (div_done) begin
          if (div_rem == '0) begin
            val_d   = div_quot;
            nd_d    = d_q;
            form_d  = 1'b0;
            state_d = S_UPD;
          end else if (last_dot) begin
            val_d   = p_q;
            nd_d    = 4'd0;
            form_d  = 1'b1;
            state_d = S_UPD;
          end else begin
            d_d     = d_q + 4'd1;
            div_go  = 1'b1;
            div_dv  = ly_nxt;
            state_d = S_D1;
          end
        end
      end
      S_UPD: begin
        // advance counters, signature and marks, then present the item
        tot_d     = tot1;
        o_mark_d  = chg ? MARK_LINE : MARK_NONE;
        sig_idx_d = chg ? nx[IW-1:0] : sig_idx_q;
        tib_d     = tib2;
        til_d     = til2;
        if (til2 >= bb4) begin
          tib_d    = (tib2 >= bb) ? tib2 - bb : 16'd0;
          til_d    = til2 - bb4;
          o_mark_d = MARK_LINE;
        end else if (tib2 >= bb) begin
          tib_d = tib2 - bb;
          if (!chg) begin
            o_mark_d = MARK_BAR;
          end
        end
        o_val_d  = val_q;
        o_nd_d   = nd_q;
        o_form_d = form_q;
        o_tied_d = (n_q != 7'd0);
        o_over_d = (n_next == PIECE_CAP) && (rem_left != 16'd0);
        o_last_d = (n_next == PIECE_CAP) || (rem_left == 16'd0);
        rem_d    = rem_left;
        n_d      = n_next;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = o_last_q ? S_IDLE : S_PLAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stage_q   <= ST_BAR;
      sig_idx_q <= '0;
      tib_q     <= '0;
      til_q     <= '0;
      tot_q     <= '0;
      rem_q     <= '0;
      n_q       <= '0;
      d_q       <= '0;
    end else begin
      state_q   <= state_d;
      stage_q   <= stage_d;
      sig_idx_q <= sig_idx_d;
      tib_q     <= tib_d;
      til_q     <= til_d;
      tot_q     <= tot_d;
      rem_q     <= rem_d;
      n_q       <= n_d;
      d_q       <= d_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    val_q    <= val_d;
    nd_q     <= nd_d;
    form_q   <= form_d;
    o_val_q  <= o_val_d;
    o_nd_q   <= o_nd_d;
    o_form_q <= o_form_d;
    o_tied_q <= o_tied_d;
    o_mark_q <= o_mark_d;
    o_over_q <= o_over_d;
    o_last_q <= o_last_d;
  end

  // ports
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {o_over_q, o_mark_q, o_tied_q, o_nd_q, o_val_q};
  assign m_axis_tuser  = o_form_q;
  assign m_axis_tlast  = o_last_q;

endmodule

[rtl/tdl_ram.sv]
// ----------------------------------------------------------------------------
// tdl_ram - generic RAM, one write port, two registered read ports
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module tdl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    ra_addr_i,
  input  logic [AW-1:0]    rb_addr_i,
  output logic [WIDTH-1:0] ra_data_o,
  output logic [WIDTH-1:0] rb_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem[ra_addr_i];
    rb_data_o <= mem[rb_addr_i];
  end

endmodule

[rtl/tdl_div.sv]
// ----------------------------------------------------------------------------
// tdl_div - bit-serial restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
module tdl_div import tdl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] a_q, r_q, dv_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          ge;

  // shift in the next dividend bit and try the subtraction
  assign trial = {r_q, a_q[DW-1]};
  assign ge    = (trial >= {1'b0, dv_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(DW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (cnt_q != '0) begin
      a_q <= {a_q[DW-2:0], ge};
      r_q <= ge ? DW'(trial - {1'b0, dv_q}) : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = a_q;
  assign rem_o  = r_q;

endmodule
